@@ design/lkvt_pkg.sv @@
// shared constants and codes for the linear key/value table
`timescale 1ns / 1ps
`default_nettype none

package lkvt_pkg;

  // table size and stored widths
  localparam int DEPTH      = 16;
  localparam int KEY_BITS   = 32;
  localparam int VALUE_BITS = 32;

  // request and response field widths
  localparam int REQ_W    = 3;
  localparam int KEY_IN_W = 32;
  localparam int VAL_IN_W = 32;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 5;

  // stored widths never exceed the request fields
  localparam int KW = (KEY_BITS < KEY_IN_W) ? KEY_BITS : KEY_IN_W;
  localparam int VW = (VALUE_BITS < VAL_IN_W) ? VALUE_BITS : VAL_IN_W;

  localparam int IDX_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  localparam logic [CNT_BITS-1:0] CNT_ZERO = '0;
  localparam logic [CNT_BITS-1:0] CNT_ONE  = CNT_BITS'(1);
  localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(DEPTH);

  // request codes
  localparam logic [REQ_W-1:0] OP_ADD    = 3'd0;
  localparam logic [REQ_W-1:0] OP_UPDATE = 3'd1;
  localparam logic [REQ_W-1:0] OP_GET    = 3'd2;
  localparam logic [REQ_W-1:0] OP_EXISTS = 3'd3;
  localparam logic [REQ_W-1:0] OP_REMOVE = 3'd4;
  localparam logic [REQ_W-1:0] OP_MINKEY = 3'd5;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd3;

endpackage

`default_nettype wire

@@ design/lkvt_ifs.sv @@
// request and response channel interfaces
`timescale 1ns / 1ps
`default_nettype none

interface lkvt_req_if;
  logic                          valid;
  logic                          ready;
  logic [lkvt_pkg::REQ_W-1:0]    req_type;
  logic [lkvt_pkg::KEY_IN_W-1:0] key;
  logic [lkvt_pkg::VAL_IN_W-1:0] value;

  modport source (output valid, req_type, key, value, input ready);
  modport sink   (input valid, req_type, key, value, output ready);
endinterface

interface lkvt_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [lkvt_pkg::STATUS_W-1:0] status;
  logic                          found;
  logic [lkvt_pkg::VAL_IN_W-1:0] value_out;
  logic [lkvt_pkg::KEY_IN_W-1:0] key_out;
  logic [lkvt_pkg::OCC_W-1:0]    occupancy;

  modport source (output valid, status, found, value_out, key_out, occupancy, input ready);
  modport sink   (input valid, status, found, value_out, key_out, occupancy, output ready);
endinterface

`default_nettype wire

@@ design/linear_key_value_table_core.sv @@
// linear key/value table: sequencer around one key/value ram
//
// req channel carries req_type, key and value; rsp channel returns one response
// per request with status, found, value_out, key_out and occupancy.
// entries live in one ram (key and value side by side) with a registered read.
// add writes its entry in the start state unless the table is full. update,
// get, exists and minkey scan the stored entries oldest first, one read per
// cycle (a search stops early at the first match). remove scans to the match
// at position p and then moves each later entry down one place, one read
// and one write per cycle. the ram's single read port sets this pace.
// one request is in the sequencer at a time; req.ready is high when it is free.
// a finished response waits in an output register, so the next request is
// taken while rsp stalls; a second response waits until the first is taken.
// reset (rst, synchronous) empties the table at once and drops any pending
// response; the ram contents are not cleared, only entries below the count
// are ever read.

`timescale 1ns / 1ps
`default_nettype none

module linear_key_value_table_core (
  input wire logic clk,
  input wire logic rst,
  lkvt_req_if.sink   req,
  lkvt_rsp_if.source rsp
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0] state;

  logic [lkvt_pkg::REQ_W-1:0]    op_q;
  logic [lkvt_pkg::KW-1:0]       key_q;
  logic [lkvt_pkg::VW-1:0]       val_q;
  logic [lkvt_pkg::CNT_BITS-1:0] count;
  logic [lkvt_pkg::CNT_BITS-1:0] ptr;
  logic [lkvt_pkg::CNT_BITS-1:0] cmp_idx;
  logic                          pend;
  logic [lkvt_pkg::KW-1:0]       best;

  logic [lkvt_pkg::STATUS_W-1:0] res_status;
  logic                          res_found;
  logic [lkvt_pkg::VAL_IN_W-1:0] res_value;
  logic [lkvt_pkg::KEY_IN_W-1:0] res_key;

  logic                          out_valid;
  logic [lkvt_pkg::STATUS_W-1:0] out_status;
  logic                          out_found;
  logic [lkvt_pkg::VAL_IN_W-1:0] out_value;
  logic [lkvt_pkg::KEY_IN_W-1:0] out_key;
  logic [lkvt_pkg::OCC_W-1:0]    out_occ;

  // ram ports
  logic                                    wr_en;
  logic [lkvt_pkg::IDX_BITS-1:0]           wr_addr;
  logic [lkvt_pkg::KW+lkvt_pkg::VW-1:0]    wr_data;
  logic                                    rd_en;
  logic [lkvt_pkg::IDX_BITS-1:0]           rd_addr;
  logic [lkvt_pkg::KW+lkvt_pkg::VW-1:0]    rd_data;

  logic [lkvt_pkg::KW-1:0]       rd_key;
  logic [lkvt_pkg::VW-1:0]       rd_val;
  logic                          issue;
  logic                          hit;
  logic                          last;
  logic                          take_min;
  logic [lkvt_pkg::KW-1:0]       min_key;
  logic [lkvt_pkg::CNT_BITS-1:0] shift_dst;

  lkvt_ram #(
    .WORDS     (lkvt_pkg::DEPTH),
    .ADDR_BITS (lkvt_pkg::IDX_BITS),
    .DATA_BITS (lkvt_pkg::KW + lkvt_pkg::VW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign rd_key    = rd_data[lkvt_pkg::KW+lkvt_pkg::VW-1:lkvt_pkg::VW];
  assign rd_val    = rd_data[lkvt_pkg::VW-1:0];
  assign issue     = ((state == S_SCAN) || (state == S_SHIFT)) && (ptr < count);
  assign hit       = pend && (rd_key == key_q);
  assign last      = pend && ((cmp_idx + lkvt_pkg::CNT_ONE) == count);
  assign take_min  = (cmp_idx == lkvt_pkg::CNT_ZERO) || (rd_key < best);
  assign min_key   = take_min ? rd_key : best;
  assign shift_dst = cmp_idx - lkvt_pkg::CNT_ONE;

  assign rd_en   = issue;
  assign rd_addr = ptr[lkvt_pkg::IDX_BITS-1:0];

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count[lkvt_pkg::IDX_BITS-1:0];
    wr_data = {key_q, val_q};
    if ((state == S_START) && (op_q == lkvt_pkg::OP_ADD) && (count < lkvt_pkg::CNT_FULL)) begin
      wr_en = 1'b1;
    end else if ((state == S_SCAN) && (op_q == lkvt_pkg::OP_UPDATE) && hit) begin
      wr_en   = 1'b1;
      wr_addr = cmp_idx[lkvt_pkg::IDX_BITS-1:0];
      wr_data = {rd_key, val_q};
    end else if ((state == S_SHIFT) && pend) begin
      // entry read last cycle moves down one place
      wr_en   = 1'b1;
      wr_addr = shift_dst[lkvt_pkg::IDX_BITS-1:0];
      wr_data = rd_data;
    end
  end

  assign req.ready     = (state == S_IDLE);
  assign rsp.valid     = out_valid;
  assign rsp.status    = out_status;
  assign rsp.found     = out_found;
  assign rsp.value_out = out_value;
  assign rsp.key_out   = out_key;
  assign rsp.occupancy = out_occ;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= lkvt_pkg::CNT_ZERO;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end

      pend <= issue;
      if (issue) begin
        ptr     <= ptr + lkvt_pkg::CNT_ONE;
        cmp_idx <= ptr;
      end

      case (state)
        S_IDLE: begin
          if (req.valid) begin
            op_q  <= req.req_type;
            key_q <= req.key[lkvt_pkg::KW-1:0];
            val_q <= req.value[lkvt_pkg::VW-1:0];
            ptr   <= lkvt_pkg::CNT_ZERO;
            state <= S_START;
          end
        end

        S_START: begin
          res_status <= lkvt_pkg::ST_OK;
          res_found  <= 1'b0;
          res_value  <= '0;
          res_key    <= '0;
          case (op_q)
            lkvt_pkg::OP_ADD: begin
              if (count < lkvt_pkg::CNT_FULL) begin
                count <= count + lkvt_pkg::CNT_ONE;
              end else begin
                res_status <= lkvt_pkg::ST_FULL;
              end
              state <= S_DONE;
            end
            lkvt_pkg::OP_UPDATE, lkvt_pkg::OP_GET, lkvt_pkg::OP_EXISTS,
            lkvt_pkg::OP_REMOVE: begin
              if (count == lkvt_pkg::CNT_ZERO) begin
                if (op_q != lkvt_pkg::OP_EXISTS) begin
                  res_status <= lkvt_pkg::ST_NOTFOUND;
                end
                state <= S_DONE;
              end else begin
                state <= S_SCAN;
              end
            end
            lkvt_pkg::OP_MINKEY: begin
              if (count == lkvt_pkg::CNT_ZERO) begin
                res_status <= lkvt_pkg::ST_EMPTY;
                state      <= S_DONE;
              end else begin
                state <= S_SCAN;
              end
            end
            default: begin
              state <= S_DONE;
            end
          endcase
        end

        S_SCAN: begin
          if (pend) begin
            if (op_q == lkvt_pkg::OP_MINKEY) begin
              best <= min_key;
              if (last) begin
                res_key <= lkvt_pkg::KEY_IN_W'(min_key);
                state   <= S_DONE;
              end
            end else if (hit) begin
              res_found <= 1'b1;
              if (op_q == lkvt_pkg::OP_GET) begin
                res_value <= lkvt_pkg::VAL_IN_W'(rd_val);
              end
              if ((op_q == lkvt_pkg::OP_REMOVE) && !last) begin
                // close the gap starting with the entry after the match
                ptr   <= cmp_idx + lkvt_pkg::CNT_ONE;
                pend  <= 1'b0;
                state <= S_SHIFT;
              end else begin
                if (op_q == lkvt_pkg::OP_REMOVE) begin
                  count <= count - lkvt_pkg::CNT_ONE;
                end
                state <= S_DONE;
              end
            end else if (last) begin
              if (op_q != lkvt_pkg::OP_EXISTS) begin
                res_status <= lkvt_pkg::ST_NOTFOUND;
              end
              state <= S_DONE;
            end
          end
        end

        S_SHIFT: begin
          if (last) begin
            count <= count - lkvt_pkg::CNT_ONE;
            state <= S_DONE;
          end
        end

        S_DONE: begin
          if (!out_valid || rsp.ready) begin
            out_valid  <= 1'b1;
            out_status <= res_status;
            out_found  <= res_found;
            out_value  <= res_value;
            out_key    <= res_key;
            out_occ    <= lkvt_pkg::OCC_W'(count);
            state      <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ design/lkvt_ram.sv @@
// simple dual-port ram, one write and one registered read per cycle
`timescale 1ns / 1ps
`default_nettype none

module lkvt_ram #(
  parameter int WORDS     = 16,
  parameter int ADDR_BITS = 4,
  parameter int DATA_BITS = 64
) (
  input  wire logic                 clk,
  input  wire logic                 wr_en,
  input  wire logic [ADDR_BITS-1:0] wr_addr,
  input  wire logic [DATA_BITS-1:0] wr_data,
  input  wire logic                 rd_en,
  input  wire logic [ADDR_BITS-1:0] rd_addr,
  output logic      [DATA_BITS-1:0] rd_data
);

  logic [DATA_BITS-1:0] mem [WORDS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ design/lkvt_check.sv @@
// port-level assertions for the key/value table, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module lkvt_check (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          rsp_valid,
  input wire logic                          rsp_ready,
  input wire logic [lkvt_pkg::STATUS_W-1:0] status,
  input wire logic                          found,
  input wire logic [lkvt_pkg::VAL_IN_W-1:0] value_out,
  input wire logic [lkvt_pkg::KEY_IN_W-1:0] key_out,
  input wire logic [lkvt_pkg::OCC_W-1:0]    occupancy
);

  // a stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(found)
      && $stable(value_out) && $stable(key_out) && $stable(occupancy))
    else $error("response changed while stalled");

  a_occ_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> occupancy <= lkvt_pkg::OCC_W'(lkvt_pkg::DEPTH))
    else $error("occupancy beyond table depth");

  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && found |-> status == lkvt_pkg::ST_OK && key_out == '0)
    else $error("match reported with bad status or key");

  // only a successful get carries a value
  a_value_found: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && value_out != '0 |-> found)
    else $error("value returned without a match");

endmodule

bind linear_key_value_table_core lkvt_check u_lkvt_check (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .status    (rsp.status),
  .found     (rsp.found),
  .value_out (rsp.value_out),
  .key_out   (rsp.key_out),
  .occupancy (rsp.occupancy)
);

`default_nettype wire
